// ===== src/psid_pkg.sv =====
// Package for the per-second unique id allocator.
// Holds the transaction structs, status codes, control structs and popcount helpers.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none
package psid_pkg;

   localparam int LIMIT_W = 17;
   localparam logic [LIMIT_W-1:0] SEQ_CEILING = 17'h10000;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'h10000;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_BAD_TYPE  = 2'd1;
   localparam logic [1:0] STATUS_BAD_COUNT = 2'd2;
   localparam logic [1:0] STATUS_EXHAUSTED = 2'd3;

   typedef struct packed {
      logic [7:0]  id_type;
      logic [7:0]  count;
      logic [31:0] now_seconds;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [63:0] id_value;
      logic        last;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic latch_req;
      logic lookup;
      logic mark_exhausted;
      logic commit;
      logic load_single;
      logic load_id;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic req_error;
      logic over_limit;
      logic slot_free;
      logic last_one;
   } sts_type;

   function automatic logic [5:0] pop32(input logic [31:0] v);
      logic [5:0] n;
      n = 6'd0;
      for (int i = 0; i < 32; i++) begin
         n = n + 6'(v[i]);
      end
      return n;
   endfunction

   function automatic logic [4:0] pop16(input logic [15:0] v);
      logic [4:0] n;
      n = 5'd0;
      for (int i = 0; i < 16; i++) begin
         n = n + 5'(v[i]);
      end
      return n;
   endfunction

   function automatic logic [3:0] pop8(input logic [7:0] v);
      logic [3:0] n;
      n = 4'd0;
      for (int i = 0; i < 8; i++) begin
         n = n + 4'(v[i]);
      end
      return n;
   endfunction

endpackage
`default_nettype wire

// ===== src/psid_dp.sv =====
// Datapath of the per-second unique id allocator: request registers, the
// per-type counter memory with valid bits, the limit register and the result register.
// Depends on psid_pkg.
`default_nettype none
module psid_dp #(
   parameter int NUM_TYPES       = 16,
   parameter int MAX_PER_REQUEST = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire psid_pkg::req_type             req_data,
   input  wire logic                          csr_valid,
   input  wire logic [psid_pkg::LIMIT_W-1:0]  csr_data,
   input  wire logic                          rsp_stall,
   output      logic                          rsp_valid,
   output      psid_pkg::rsp_type             rsp_data,
   input  wire psid_pkg::cmd_type             cmd,
   output      psid_pkg::sts_type             sts
);

   localparam int IdxW = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
   localparam int CntW = $clog2(MAX_PER_REQUEST + 1);

   logic [7:0]                   type_ff;
   logic [CntW-1:0]              count_ff;
   logic [31:0]                  now_ff;
   logic [1:0]                   err_ff,        err_in;
   logic [31:0]                  cur_sec_ff;
   logic [NUM_TYPES-1:0]         valid_ff;
   logic [psid_pkg::LIMIT_W-1:0] cnt_mem_ff [NUM_TYPES];
   logic [psid_pkg::LIMIT_W-1:0] rd_ff;
   logic [15:0]                  seq_ff;
   logic [CntW-1:0]              remain_ff;
   logic [5:0]                   pop_base_ff;
   logic [psid_pkg::LIMIT_W-1:0] limit_ff;
   logic                         rsp_valid_ff,  rsp_valid_in;
   psid_pkg::rsp_type            rsp_data_ff;

   logic [IdxW-1:0]              idx;
   logic [psid_pkg::LIMIT_W-1:0] start;
   logic [psid_pkg::LIMIT_W-1:0] lim;
   logic [psid_pkg::LIMIT_W:0]   sum;
   logic                         slot_free;
   logic [7:0]                   id_pop;

   assign idx   = type_ff[IdxW-1:0];
   assign start = valid_ff[idx] ? rd_ff : '0;
   // Anything above 65536 behaves as 65536 so sequence numbers stay in 16 bits.
   assign lim   = limit_ff[psid_pkg::LIMIT_W-1] ? psid_pkg::SEQ_CEILING : limit_ff;
   assign sum   = (psid_pkg::LIMIT_W+1)'(start) + (psid_pkg::LIMIT_W+1)'(count_ff);
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign id_pop    = 8'(pop_base_ff) + 8'(psid_pkg::pop16(seq_ff));

   assign sts.req_error  = (err_ff != psid_pkg::STATUS_OK);
   assign sts.over_limit = (sum > (psid_pkg::LIMIT_W+1)'(lim));
   assign sts.slot_free  = slot_free;
   assign sts.last_one   = (remain_ff == CntW'(1));

   // A bad type wins over a bad count.
   always_comb begin
      err_in = err_ff;
      if (cmd.latch_req) begin
         if ((req_data.id_type == 8'd0) || (9'(req_data.id_type) >= 9'(NUM_TYPES))) begin
            err_in = psid_pkg::STATUS_BAD_TYPE;
         end else if ((req_data.count == 8'd0) ||
                      (9'(req_data.count) > 9'(MAX_PER_REQUEST))) begin
            err_in = psid_pkg::STATUS_BAD_COUNT;
         end else begin
            err_in = psid_pkg::STATUS_OK;
         end
      end else if (cmd.mark_exhausted) begin
         err_in = psid_pkg::STATUS_EXHAUSTED;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_single || cmd.load_id) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      err_ff <= err_in;
      if (cmd.latch_req) begin
         type_ff  <= req_data.id_type;
         count_ff <= req_data.count[CntW-1:0];
         now_ff   <= req_data.now_seconds;
      end
      if (cmd.lookup) begin
         pop_base_ff <= psid_pkg::pop32(now_ff) + 6'(psid_pkg::pop8(type_ff));
      end
      if (cmd.commit) begin
         seq_ff    <= start[15:0];
         remain_ff <= count_ff;
      end else if (cmd.load_id) begin
         seq_ff    <= seq_ff + 16'd1;
         remain_ff <= remain_ff - CntW'(1);
      end
      if (cmd.load_single) begin
         rsp_data_ff.status   <= err_ff;
         rsp_data_ff.id_value <= 64'd0;
         rsp_data_ff.last     <= 1'b1;
      end else if (cmd.load_id) begin
         rsp_data_ff.status   <= psid_pkg::STATUS_OK;
         rsp_data_ff.id_value <= {now_ff, seq_ff, type_ff, id_pop};
         rsp_data_ff.last     <= sts.last_one;
      end
   end

   // Counter memory: read during lookup, written at commit.
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         cnt_mem_ff[idx] <= sum[psid_pkg::LIMIT_W-1:0];
      end
      if (cmd.lookup) begin
         rd_ff <= cnt_mem_ff[idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_sec_ff   <= '0;
         valid_ff     <= '0;
         limit_ff     <= psid_pkg::LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            limit_ff <= csr_data;
         end
         // A new second invalidates every counter at once.
         if (cmd.lookup && (now_ff != cur_sec_ff)) begin
            cur_sec_ff <= now_ff;
            valid_ff   <= '0;
         end else if (cmd.commit) begin
            valid_ff[idx] <= 1'b1;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

// ===== src/psid_ctrl.sv =====
// Controller of the per-second unique id allocator: the request sequencer.
// Depends on psid_pkg; drives the datapath through cmd_type and reads sts_type.
`default_nettype none
module psid_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_stall,
   input  wire psid_pkg::sts_type sts,
   output      psid_pkg::cmd_type cmd
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_LOOKUP = 5'b00010,
      ST_CHECK  = 5'b00100,
      ST_SINGLE = 5'b01000,
      ST_EMIT   = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in      = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (sts.req_error) begin
               state_in = ST_SINGLE;
            end else begin
               cmd.lookup = 1'b1;
               state_in   = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (sts.over_limit) begin
               cmd.mark_exhausted = 1'b1;
               state_in           = ST_SINGLE;
            end else begin
               cmd.commit = 1'b1;
               state_in   = ST_EMIT;
            end
         end
         ST_SINGLE: begin
            if (sts.slot_free) begin
               cmd.load_single = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (sts.slot_free) begin
               cmd.load_id = 1'b1;
               if (sts.last_one) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule
`default_nettype wire

// ===== src/per_second_unique_id_allocator_top.sv =====
// Top level of the per-second unique id allocator.
// Depends on psid_pkg, psid_ctrl and psid_dp.
//
//   Channel   Direction  Handshake             Payload
//   req_      in         req_valid/req_stall   psid_pkg::req_type (id_type, count, now_seconds)
//   rsp_      out        rsp_valid/rsp_stall   psid_pkg::rsp_type (status, id_value, last)
//   csr_      in         csr_valid/csr_ready   ids_per_second_limit, 17 bits
//
// A good request goes through accept, counter read and limit check with write-back, then one
// id per cycle from the single result register while the result side does not stall. A bad
// type or count ends in one result load after accept, an exhausted one after the check.
// Reset is synchronous and active high; it invalidates every counter, zeroes the current
// second and sets the limit to 65536, so no clearing pass is needed after reset.
// A result stall holds the result register and pauses id generation; the next request is
// accepted in the cycle after the previous request's last result is loaded.
`default_nettype none
module per_second_unique_id_allocator_top #(
   parameter int NUM_TYPES       = 16,
   parameter int MAX_PER_REQUEST = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output      logic                          req_stall,
   input  wire psid_pkg::req_type             req_data,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   output      psid_pkg::rsp_type             rsp_data,
   input  wire logic                          csr_valid,
   output      logic                          csr_ready,
   input  wire logic [psid_pkg::LIMIT_W-1:0]  csr_data
);

   psid_pkg::cmd_type cmd;
   psid_pkg::sts_type sts;

   // The limit register takes a write in any cycle, so the port is always ready.
   assign csr_ready = 1'b1;

   // The sequencer walks a good request through lookup, check and emission; a bad one ends in a single result.
   psid_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The datapath owns the request, counter, limit and result storage, including the per-type sequence counters.
   psid_dp #(
      .NUM_TYPES       (NUM_TYPES),
      .MAX_PER_REQUEST (MAX_PER_REQUEST)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule
`default_nettype wire

// ===== src/psid_checker.sv =====
// Port-level checker for the per-second unique id allocator, with its bind statement.
// Depends on psid_pkg and the ports of per_second_unique_id_allocator_top.
`default_nettype none
module psid_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire psid_pkg::rsp_type rsp_data
);

   // A stalled result transaction holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // The block works on one request at a time.
   a_one_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while another was in flight");

   // Error and exhausted results are single, final and carry a zero id.
   a_err_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != psid_pkg::STATUS_OK) |->
         rsp_data.last && (rsp_data.id_value == 64'd0))
      else $error("malformed error result");

   // The low byte of an id counts the one bits of the second, sequence and type.
   a_id_pop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == psid_pkg::STATUS_OK) |->
         (($countones(rsp_data.id_value[63:32]) + $countones(rsp_data.id_value[31:16])
           + $countones(rsp_data.id_value[15:8])) == int'(rsp_data.id_value[7:0])))
      else $error("id check byte mismatch");

   // A good id never carries type zero.
   a_id_type: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == psid_pkg::STATUS_OK) |->
         (rsp_data.id_value[15:8] != 8'd0))
      else $error("id with type zero");

endmodule

bind per_second_unique_id_allocator_top psid_checker u_psid_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
`default_nettype wire
